// ===== rtl/acmm_pkg.sv =====
// Shared constants, types and helpers of the audio channel mix matrix.
package acmm_pkg;

	localparam int MAX_IN_CH      = 8;
	localparam int MAX_OUT_CH     = 8;
	localparam int SAMPLE_BITS    = 24;
	localparam int GAIN_BITS      = 16;
	localparam int GAIN_FRAC_BITS = 12;
	localparam int CH_W           = 3;
	localparam int CNT_W          = 4;
	localparam int CFG_IDX_W      = 1;
	localparam int GADDR_W        = 2 * CH_W;
	localparam int GAIN_DEPTH     = MAX_IN_CH * MAX_OUT_CH;
	localparam int PROD_W         = GAIN_BITS + SAMPLE_BITS;
	localparam int ACC_W          = PROD_W + CH_W;
	localparam int SUM_W          = ACC_W - GAIN_FRAC_BITS + 1;
	localparam int QDEPTH         = 2;

	// Item operation codes.
	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_GAIN   = 2'd1,
		OP_OFFSET = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IN_USED  = 1'b0,
		REG_OUT_USED = 1'b1
	} cfg_reg_t;

	// Back end sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_WAIT
	} back_state_t;

	// Channel counts, held as index of the last used channel.
	typedef struct packed {
		logic [CH_W-1:0] in_last;
		logic [CH_W-1:0] out_last;
	} cfg_t;

	// Table writes from the front end.
	typedef struct packed {
		logic                   gain_en;
		logic                   offset_en;
		logic [CH_W-1:0]        out_ch;
		logic [CH_W-1:0]        in_ch;
		logic [GAIN_BITS-1:0]   gain;
		logic [SAMPLE_BITS-1:0] offset;
	} load_t;

	// Status of the back end seen by the front end.
	typedef struct packed {
		logic idle;
	} back_stat_t;

	// One complete frame of input samples.
	typedef logic [MAX_IN_CH-1:0][SAMPLE_BITS-1:0] frame_t;

	// A count of zero acts as one, a count above the maximum acts as the maximum.
	function automatic logic [CH_W-1:0] clamp_last(logic [CNT_W-1:0] v, logic [CNT_W-1:0] lim);
		logic [CH_W-1:0] r;
		if (v == '0)
			r = '0;
		else if (v > lim)
			r = CH_W'(lim - CNT_W'(1));
		else
			r = CH_W'(v - CNT_W'(1));
		return r;
	endfunction

endpackage

// ===== rtl/audio_channel_mix_matrix.sv =====
// Intake: a non-final sample is never held back; the sample that completes a frame waits
// while the two-entry job queue is full, and load items wait until the queue is empty and
// the mixer is idle. Frames are mixed one output channel at a time on the single shared
// multiply-accumulate unit, which waits while the receiver stalls.
// Reset (arst_n, asynchronous): tables and frame store read as zero, counts are one.
module audio_channel_mix_matrix (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [acmm_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [acmm_pkg::CNT_W-1:0]              cfg_wdata,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [1:0]                              op,
	input  logic [acmm_pkg::CH_W-1:0]               in_channel,
	input  logic [acmm_pkg::CH_W-1:0]               out_channel,
	input  logic signed [acmm_pkg::SAMPLE_BITS-1:0] sample,
	input  logic signed [acmm_pkg::GAIN_BITS-1:0]   gain_value,
	input  logic signed [acmm_pkg::SAMPLE_BITS-1:0] offset_value,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [acmm_pkg::CH_W-1:0]               mixed_channel,
	output logic signed [acmm_pkg::SAMPLE_BITS-1:0] mixed_value,
	output logic                                    frame_last
);

	logic                 q_push, q_pop, q_full, q_empty;
	acmm_pkg::frame_t     q_wdata, q_rdata;
	acmm_pkg::load_t      load;
	acmm_pkg::cfg_t       cfg;
	acmm_pkg::back_stat_t stat;

	// Item intake and frame store.
	acmm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.in_channel   (in_channel),
		.out_channel  (out_channel),
		.sample       (sample),
		.gain_value   (gain_value),
		.offset_value (offset_value),
		.q_full       (q_full),
		.q_empty      (q_empty),
		.stat         (stat),
		.q_push       (q_push),
		.q_data       (q_wdata),
		.load         (load),
		.cfg          (cfg)
	);

	// Frame job queue.
	acmm_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	// Mixing engine.
	acmm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.load          (load),
		.q_empty       (q_empty),
		.q_rdata       (q_rdata),
		.q_pop         (q_pop),
		.stat          (stat),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.mixed_channel (mixed_channel),
		.mixed_value   (mixed_value),
		.frame_last    (frame_last)
	);

endmodule

// ===== rtl/acmm_fifo.sv =====
// Short queue of frame jobs between the front end and the back end.
module acmm_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  acmm_pkg::frame_t wdata,
	input  logic            pop,
	output acmm_pkg::frame_t rdata,
	output logic            full,
	output logic            empty
);

	localparam int PTR_W = (acmm_pkg::QDEPTH > 1) ? $clog2(acmm_pkg::QDEPTH) : 1;
	localparam int CNT_W = $clog2(acmm_pkg::QDEPTH + 1);

	acmm_pkg::frame_t  entry_q [acmm_pkg::QDEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full  = (count_q == CNT_W'(acmm_pkg::QDEPTH));
	assign empty = (count_q == '0);
	assign rdata = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= wdata;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(acmm_pkg::QDEPTH - 1)) ? '0 :
					wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(acmm_pkg::QDEPTH - 1)) ? '0 :
					rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

// ===== rtl/acmm_front.sv =====
// Front end: takes items, holds configuration and frame store, queues frame jobs.
module acmm_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [acmm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [acmm_pkg::CNT_W-1:0]           cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           op,
	input  logic [acmm_pkg::CH_W-1:0]            in_channel,
	input  logic [acmm_pkg::CH_W-1:0]            out_channel,
	input  logic signed [acmm_pkg::SAMPLE_BITS-1:0] sample,
	input  logic signed [acmm_pkg::GAIN_BITS-1:0]   gain_value,
	input  logic signed [acmm_pkg::SAMPLE_BITS-1:0] offset_value,
	input  logic                                 q_full,
	input  logic                                 q_empty,
	input  acmm_pkg::back_stat_t                 stat,
	output logic                                 q_push,
	output acmm_pkg::frame_t                     q_data,
	output acmm_pkg::load_t                      load,
	output acmm_pkg::cfg_t                       cfg
);

	logic [acmm_pkg::CNT_W-1:0] in_used_q;
	logic [acmm_pkg::CNT_W-1:0] out_used_q;
	acmm_pkg::frame_t           frame_q;
	acmm_pkg::op_t              opc;
	logic                       accept;
	logic                       in_range;
	logic                       is_trig;

	// Clamp the channel counts to the supported range.
	always_comb begin
		cfg.in_last  = acmm_pkg::clamp_last(in_used_q, acmm_pkg::CNT_W'(acmm_pkg::MAX_IN_CH));
		cfg.out_last = acmm_pkg::clamp_last(out_used_q, acmm_pkg::CNT_W'(acmm_pkg::MAX_OUT_CH));
	end

	// Classify the item and decide whether it can be taken now.
	always_comb begin
		opc      = acmm_pkg::op_t'(op);
		in_range = (in_channel <= cfg.in_last);
		is_trig  = (in_channel == cfg.in_last);
		unique case (opc)
			acmm_pkg::OP_SAMPLE: in_ready = !is_trig || !q_full;
			acmm_pkg::OP_GAIN:   in_ready = q_empty && stat.idle;
			acmm_pkg::OP_OFFSET: in_ready = q_empty && stat.idle;
			acmm_pkg::OP_NONE:   in_ready = 1'b1;
		endcase
		accept = in_valid && in_ready;
	end

	// Table writes go to the back end, which owns the gain and offset tables.
	always_comb begin
		load.gain_en   = accept && (opc == acmm_pkg::OP_GAIN);
		load.offset_en = accept && (opc == acmm_pkg::OP_OFFSET);
		load.out_ch    = out_channel;
		load.in_ch     = in_channel;
		load.gain      = gain_value;
		load.offset    = offset_value;
	end

	// The last used channel completes the frame: queue a snapshot including it.
	always_comb begin
		q_push = accept && (opc == acmm_pkg::OP_SAMPLE) && is_trig;
		for (int i = 0; i < acmm_pkg::MAX_IN_CH; i++) begin
			if (in_channel == acmm_pkg::CH_W'(i))
				q_data[i] = sample;
			else
				q_data[i] = frame_q[i];
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_used_q  <= acmm_pkg::CNT_W'(1);
			out_used_q <= acmm_pkg::CNT_W'(1);
		end else if (cfg_we) begin
			unique case (acmm_pkg::cfg_reg_t'(cfg_index))
				acmm_pkg::REG_IN_USED:  in_used_q  <= cfg_wdata;
				acmm_pkg::REG_OUT_USED: out_used_q <= cfg_wdata;
			endcase
		end
	end

	// Frame store; samples for unused channels are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
		end else if (accept && (opc == acmm_pkg::OP_SAMPLE) && in_range) begin
			frame_q[in_channel] <= sample;
		end
	end

endmodule

// ===== rtl/acmm_back.sv =====
// Back end: shared multiply-accumulate over one frame job, with gain and offset tables.
module acmm_back (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  acmm_pkg::cfg_t                        cfg,
	input  acmm_pkg::load_t                       load,
	input  logic                                  q_empty,
	input  acmm_pkg::frame_t                      q_rdata,
	output logic                                  q_pop,
	output acmm_pkg::back_stat_t                  stat,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [acmm_pkg::CH_W-1:0]             mixed_channel,
	output logic signed [acmm_pkg::SAMPLE_BITS-1:0] mixed_value,
	output logic                                  frame_last
);

	localparam logic signed [acmm_pkg::SUM_W-1:0] SAT_MAX =
		acmm_pkg::SUM_W'((64'sd1 <<< (acmm_pkg::SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [acmm_pkg::SUM_W-1:0] SAT_MIN =
		acmm_pkg::SUM_W'(-(64'sd1 <<< (acmm_pkg::SAMPLE_BITS - 1)));

	// Tables.
	logic [acmm_pkg::GAIN_BITS-1:0]   gain_mem [acmm_pkg::GAIN_DEPTH];
	logic [acmm_pkg::GAIN_DEPTH-1:0]  gain_vld_q;
	logic [acmm_pkg::SAMPLE_BITS-1:0] offset_q [acmm_pkg::MAX_OUT_CH];
	acmm_pkg::frame_t                 job_q;

	// Sequencer.
	acmm_pkg::back_state_t   state_q, state_d;
	logic [acmm_pkg::CH_W-1:0] k_q, k_d, m_q, m_d;
	logic                    issue;
	logic [acmm_pkg::GADDR_W-1:0] raddr;

	// Pipeline.
	logic                                   valid_s1, first_s1, last_s1;
	logic [acmm_pkg::CH_W-1:0]              k_s1;
	logic signed [acmm_pkg::SAMPLE_BITS-1:0] samp_s1;
	logic [acmm_pkg::GAIN_BITS-1:0]         gain_rd_s1;
	logic                                   gain_vld_s1;
	logic signed [acmm_pkg::GAIN_BITS-1:0]  gain_eff;
	logic                                   valid_s2, first_s2, last_s2;
	logic [acmm_pkg::CH_W-1:0]              k_s2;
	logic signed [acmm_pkg::PROD_W-1:0]     prod_s2;
	logic signed [acmm_pkg::ACC_W-1:0]      acc_q;
	logic                                   done_q;
	logic [acmm_pkg::CH_W-1:0]              fin_k_q;

	// Finalize and output.
	logic signed [acmm_pkg::ACC_W-1:0]       shifted;
	logic signed [acmm_pkg::SUM_W-1:0]       sum;
	logic signed [acmm_pkg::SAMPLE_BITS-1:0] sat;
	logic                                    out_load;
	logic                                    out_valid_q;
	logic [acmm_pkg::CH_W-1:0]               out_ch_q;
	logic [acmm_pkg::SAMPLE_BITS-1:0]        out_val_q;
	logic                                    out_last_q;

	assign raddr      = {k_q, m_q};
	assign stat.idle  = (state_q == acmm_pkg::ST_IDLE);
	assign out_load   = done_q && (!out_valid_q || out_ready);

	// Gain memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (load.gain_en)
			gain_mem[{load.out_ch, load.in_ch}] <= load.gain;
		gain_rd_s1 <= gain_mem[raddr];
	end

	// Written marks for the gain memory; an unwritten entry reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_vld_q  <= '0;
			gain_vld_s1 <= 1'b0;
		end else begin
			if (load.gain_en)
				gain_vld_q[{load.out_ch, load.in_ch}] <= 1'b1;
			gain_vld_s1 <= gain_vld_q[raddr];
		end
	end

	// Offset table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < acmm_pkg::MAX_OUT_CH; i++)
				offset_q[i] <= '0;
		end else if (load.offset_en) begin
			offset_q[load.out_ch] <= load.offset;
		end
	end

	// Frame job taken from the queue.
	always_ff @(posedge clk) begin
		if (q_pop)
			job_q <= q_rdata;
	end

	// Sequencer: per output channel, issue one product per input channel,
	// then wait until that channel's result has moved to the output register.
	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		m_d     = m_q;
		q_pop   = 1'b0;
		issue   = 1'b0;
		unique case (state_q)
			acmm_pkg::ST_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					k_d     = '0;
					m_d     = '0;
					state_d = acmm_pkg::ST_RUN;
				end
			end
			acmm_pkg::ST_RUN: begin
				issue = 1'b1;
				if (m_q == cfg.in_last) begin
					m_d     = '0;
					state_d = acmm_pkg::ST_WAIT;
				end else begin
					m_d = m_q + acmm_pkg::CH_W'(1);
				end
			end
			acmm_pkg::ST_WAIT: begin
				if (out_load) begin
					if (k_q == cfg.out_last) begin
						state_d = acmm_pkg::ST_IDLE;
					end else begin
						k_d     = k_q + acmm_pkg::CH_W'(1);
						state_d = acmm_pkg::ST_RUN;
					end
				end
			end
			default: state_d = acmm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= acmm_pkg::ST_IDLE;
			k_q     <= '0;
			m_q     <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			m_q     <= m_d;
		end
	end

	// Pipeline control flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			if (valid_s2 && last_s2)
				done_q <= 1'b1;
			else if (out_load)
				done_q <= 1'b0;
		end
	end

	// Stage 1 holds the sample beside the registered gain read.
	always_ff @(posedge clk) begin
		first_s1 <= (m_q == '0);
		last_s1  <= (m_q == cfg.in_last);
		k_s1     <= k_q;
		samp_s1  <= job_q[m_q];
	end

	// Stage 2 holds the product.
	assign gain_eff = gain_vld_s1 ? gain_rd_s1 : '0;

	always_ff @(posedge clk) begin
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		k_s2     <= k_s1;
		prod_s2  <= acmm_pkg::PROD_W'(gain_eff) * acmm_pkg::PROD_W'(samp_s1);
	end

	// Accumulator, restarted on the first input channel of each output.
	always_ff @(posedge clk) begin
		if (valid_s2) begin
			if (first_s2)
				acc_q <= acmm_pkg::ACC_W'(prod_s2);
			else
				acc_q <= acc_q + acmm_pkg::ACC_W'(prod_s2);
			fin_k_q <= k_s2;
		end
	end

	// Floor by the gain fraction, add the offset and saturate.
	always_comb begin
		shifted = acc_q >>> acmm_pkg::GAIN_FRAC_BITS;
		sum     = acmm_pkg::SUM_W'(shifted) +
			acmm_pkg::SUM_W'($signed(offset_q[fin_k_q]));
		if (sum > SAT_MAX)
			sat = acmm_pkg::SAMPLE_BITS'(SAT_MAX);
		else if (sum < SAT_MIN)
			sat = acmm_pkg::SAMPLE_BITS'(SAT_MIN);
		else
			sat = acmm_pkg::SAMPLE_BITS'(sum);
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ch_q   <= fin_k_q;
			out_val_q  <= sat;
			out_last_q <= (fin_k_q == cfg.out_last);
		end
	end

	assign out_valid     = out_valid_q;
	assign mixed_channel = out_ch_q;
	assign mixed_value   = out_val_q;
	assign frame_last    = out_last_q;

endmodule

// ===== tb/sv/audio_channel_mix_matrix_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the audio channel mix matrix: directed and random traffic.
module audio_channel_mix_matrix_test;

	// Cycles to let the block finish a load before a register write.
	localparam int SETTLE_CYCLES  = 24;
	// Cycles to watch for stray results after the last expected one.
	localparam int TRAILER_CYCLES = 120;
	localparam int SB             = acmm_pkg::SAMPLE_BITS;
	localparam int GB             = acmm_pkg::GAIN_BITS;
	localparam int CW             = acmm_pkg::CH_W;
	localparam int NW             = acmm_pkg::CNT_W;
	localparam int N_IN_MAX       = acmm_pkg::MAX_IN_CH;
	localparam int N_OUT_MAX      = acmm_pkg::MAX_OUT_CH;
	localparam longint MIX_MAX    = (longint'(1) <<< (SB - 1)) - 1;
	localparam longint MIX_MIN    = -MIX_MAX - 1;

	typedef struct {
		logic [CW-1:0]        channel;
		logic signed [SB-1:0] value;
		logic                 last;
	} mixed_sample_t;

	logic                                   clk = 1'b0;
	logic                                   arst_n;
	logic                                   cfg_we;
	logic [acmm_pkg::CFG_IDX_W-1:0]         cfg_index;
	logic [NW-1:0]                          cfg_wdata;
	logic                                   in_valid;
	logic                                   in_ready;
	logic [1:0]                             op;
	logic [CW-1:0]                          in_channel;
	logic [CW-1:0]                          out_channel;
	logic signed [SB-1:0]                   sample;
	logic signed [GB-1:0]                   gain_value;
	logic signed [SB-1:0]                   offset_value;
	logic                                   out_valid;
	logic                                   out_ready;
	logic [CW-1:0]                          mixed_channel;
	logic signed [SB-1:0]                   mixed_value;
	logic                                   frame_last;

	// Mirror of the block's tables, frame store and channel counts.
	logic signed [GB-1:0] gain_coef [N_OUT_MAX][N_IN_MAX];
	logic signed [SB-1:0] dc_offset [N_OUT_MAX];
	logic signed [SB-1:0] held_sample [N_IN_MAX];
	logic [NW-1:0]        in_count_reg;
	logic [NW-1:0]        out_count_reg;

	mixed_sample_t expected_mix [$];
	int            idle_pct;
	int            stall_pct;
	int            fail_count;

	audio_channel_mix_matrix i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.in_channel   (in_channel),
		.out_channel  (out_channel),
		.sample       (sample),
		.gain_value   (gain_value),
		.offset_value (offset_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.mixed_channel(mixed_channel),
		.mixed_value  (mixed_value),
		.frame_last   (frame_last)
	);

	always #5 clk = ~clk;

	// A count of zero acts as one; a count above the maximum acts as the maximum.
	function automatic int used_channels(logic [NW-1:0] cnt_value, int limit);
		int n;
		n = int'(cnt_value);
		if (n == 0)
			n = 1;
		else if (n > limit)
			n = limit;
		return n;
	endfunction

	// Gains are either anywhere in range or between -2.0 and 2.0, so that not every mix saturates.
	function automatic logic signed [GB-1:0] rand_gain();
		logic signed [GB-1:0] g;
		if ($urandom_range(0, 1)) begin
			g = GB'($urandom);
		end else begin
			g = GB'($urandom_range(0, 16384));
			g = g - 16'sd8192;
		end
		return g;
	endfunction

	function automatic logic signed [SB-1:0] rand_level();
		logic signed [SB-1:0] v;
		if ($urandom_range(0, 1)) begin
			v = SB'($urandom);
		end else begin
			v = SB'($urandom_range(0, 131072));
			v = v - 24'sd65536;
		end
		return v;
	endfunction

	// Update the mirror for one accepted item and queue the mixed samples it causes.
	task automatic predict_item(acmm_pkg::op_t kind, logic [CW-1:0] ich, logic [CW-1:0] och,
			logic signed [SB-1:0] smp, logic signed [GB-1:0] gn,
			logic signed [SB-1:0] ofs);
		int            n_in;
		int            n_out;
		longint        acc;
		longint        level;
		mixed_sample_t res;
		n_in  = used_channels(in_count_reg, N_IN_MAX);
		n_out = used_channels(out_count_reg, N_OUT_MAX);
		case (kind)
			acmm_pkg::OP_GAIN: begin
				gain_coef[och][ich] = gn;
			end
			acmm_pkg::OP_OFFSET: begin
				dc_offset[och] = ofs;
			end
			acmm_pkg::OP_SAMPLE: begin
				if (int'(ich) < n_in) begin
					held_sample[ich] = smp;
					// The last used input channel closes the frame.
					if (int'(ich) == n_in - 1) begin
						for (int k = 0; k < n_out; k++) begin
							acc = 0;
							for (int m = 0; m < n_in; m++)
								acc += longint'(gain_coef[k][m]) * longint'(held_sample[m]);
							level = (acc >>> acmm_pkg::GAIN_FRAC_BITS) + longint'(dc_offset[k]);
							if (level > MIX_MAX)
								level = MIX_MAX;
							if (level < MIX_MIN)
								level = MIX_MIN;
							res.channel = CW'(k);
							res.value   = SB'(level);
							res.last    = (k == n_out - 1);
							expected_mix.push_back(res);
						end
					end
				end
			end
			default: begin
			end
		endcase
	endtask

	// Offer one item, wait for its transfer and predict its results; valid stays high.
	task automatic send_item(acmm_pkg::op_t kind, logic [CW-1:0] ich, logic [CW-1:0] och,
			logic signed [SB-1:0] smp, logic signed [GB-1:0] gn,
			logic signed [SB-1:0] ofs);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		op           <= kind;
		in_channel   <= ich;
		out_channel  <= och;
		sample       <= smp;
		gain_value   <= gn;
		offset_value <= ofs;
		do
			@(posedge clk);
		while (!in_ready);
		predict_item(kind, ich, och, smp, gn, ofs);
	endtask

	// Stop sending and wait until every expected mixed sample has arrived.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_mix.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both channel counts; only called while the block is idle.
	task automatic write_counts(logic [NW-1:0] in_cnt, logic [NW-1:0] out_cnt);
		cfg_we    <= 1'b1;
		cfg_index <= acmm_pkg::REG_IN_USED;
		cfg_wdata <= in_cnt;
		@(posedge clk);
		cfg_index <= acmm_pkg::REG_OUT_USED;
		cfg_wdata <= out_cnt;
		@(posedge clk);
		cfg_we        <= 1'b0;
		in_count_reg  = in_cnt;
		out_count_reg = out_cnt;
	endtask

	// Default counts and zero tables: one output, ignored items cause nothing.
	task automatic test_after_reset();
		send_item(acmm_pkg::OP_SAMPLE, 3'd0, 3'd0, 24'sh7FFFFF, 16'sh7FFF, 24'sh7FFFFF);
		send_item(acmm_pkg::OP_NONE, 3'd7, 3'd7, 24'sh800000, 16'sh8000, 24'sh800000);
		send_item(acmm_pkg::OP_SAMPLE, 3'd5, 3'd0, 24'sh123456, 16'sh0000, 24'sh000000);
		wait_idle();
	endtask

	// Extreme gains, offsets and samples: saturation both ways and floor of negative sums.
	task automatic test_saturation_and_floor();
		write_counts(4'd2, 4'd2);
		send_item(acmm_pkg::OP_GAIN, 3'd0, 3'd0, 24'sh000000, 16'sh7FFF, 24'sh000000);
		send_item(acmm_pkg::OP_GAIN, 3'd1, 3'd0, 24'sh000000, 16'sh8000, 24'sh000000);
		send_item(acmm_pkg::OP_GAIN, 3'd0, 3'd1, 24'sh000000, 16'sh8000, 24'sh000000);
		send_item(acmm_pkg::OP_GAIN, 3'd1, 3'd1, 24'sh000000, 16'sh8000, 24'sh000000);
		send_item(acmm_pkg::OP_OFFSET, 3'd0, 3'd0, 24'sh000000, 16'sh0000, 24'sh7FFFFF);
		send_item(acmm_pkg::OP_OFFSET, 3'd0, 3'd1, 24'sh000000, 16'sh0000, 24'sh800000);
		send_item(acmm_pkg::OP_SAMPLE, 3'd0, 3'd0, 24'sh7FFFFF, 16'sh0000, 24'sh000000);
		send_item(acmm_pkg::OP_SAMPLE, 3'd1, 3'd0, 24'sh800000, 16'sh0000, 24'sh000000);
		// Only the closing sample: input channel 0 keeps its previous value.
		send_item(acmm_pkg::OP_SAMPLE, 3'd1, 3'd0, 24'sh7FFFFF, 16'sh0000, 24'sh000000);
		wait_idle();
	endtask

	// Counts of zero and above the maximum.
	task automatic test_count_limits();
		write_counts(4'd0, 4'd15);
		send_item(acmm_pkg::OP_SAMPLE, 3'd0, 3'd0, 24'sh400000, 16'sh0000, 24'sh000000);
		wait_idle();
		write_counts(4'd15, 4'd0);
		for (int ch = 0; ch < N_IN_MAX; ch++)
			send_item(acmm_pkg::OP_SAMPLE, CW'(ch), 3'd0,
				(ch % 2) ? 24'sh800000 : 24'sh7FFFFF, 16'sh0000, 24'sh000000);
		wait_idle();
	endtask

	// Mostly whole frames with random content, mixed with loads, broken frames and noise.
	task automatic test_random_traffic(int idle, int stall, logic [NW-1:0] in_cnt,
			logic [NW-1:0] out_cnt, int item_goal);
		int n_items;
		int pick;
		int n_in;
		wait_idle();
		idle_pct  = idle;
		stall_pct = stall;
		write_counts(in_cnt, out_cnt);
		n_in    = used_channels(in_count_reg, N_IN_MAX);
		n_items = 0;
		while (n_items < item_goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 62) begin
				for (int ch = 0; ch < n_in; ch++)
					send_item(acmm_pkg::OP_SAMPLE, CW'(ch), CW'($urandom), SB'($urandom),
						GB'($urandom), SB'($urandom));
				n_items += n_in;
			end else if (pick < 76) begin
				send_item(acmm_pkg::OP_GAIN, CW'($urandom), CW'($urandom), SB'($urandom),
					rand_gain(), SB'($urandom));
				n_items++;
			end else if (pick < 86) begin
				send_item(acmm_pkg::OP_OFFSET, CW'($urandom), CW'($urandom), SB'($urandom),
					GB'($urandom), rand_level());
				n_items++;
			end else if (pick < 91) begin
				// A stray sample on a used channel, out of frame order.
				send_item(acmm_pkg::OP_SAMPLE, CW'($urandom_range(0, n_in - 1)), CW'($urandom),
					rand_level(), GB'($urandom), SB'($urandom));
				n_items++;
			end else if (pick < 97) begin
				if (n_in < N_IN_MAX && $urandom_range(0, 1))
					send_item(acmm_pkg::OP_SAMPLE, CW'($urandom_range(n_in, N_IN_MAX - 1)),
						CW'($urandom), SB'($urandom), GB'($urandom), SB'($urandom));
				else
					send_item(acmm_pkg::OP_NONE, CW'($urandom), CW'($urandom), SB'($urandom),
						GB'($urandom), SB'($urandom));
				n_items++;
			end else begin
				wait_idle();
			end
		end
	endtask

	// Receiver stalls at the rate of the current phase.
	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= stall_pct);

	// Compare every mixed sample transfer with the oldest expectation.
	always @(posedge clk) begin : check_results
		mixed_sample_t want;
		if (out_valid && out_ready) begin
			if (expected_mix.size() == 0) begin
				$error("unexpected mixed sample: channel %0d value %0d last %0b",
					mixed_channel, mixed_value, frame_last);
				fail_count++;
			end else begin
				want = expected_mix.pop_front();
				if (mixed_channel !== want.channel) begin
					$error("mixed_channel: expected %0d, got %0d", want.channel, mixed_channel);
					fail_count++;
				end
				if (mixed_value !== want.value) begin
					$error("mixed_value: expected %0d, got %0d", want.value, mixed_value);
					fail_count++;
				end
				if (frame_last !== want.last) begin
					$error("frame_last: expected %0b, got %0b", want.last, frame_last);
					fail_count++;
				end
			end
		end
	end

	initial begin : run_tests
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = acmm_pkg::REG_IN_USED;
		cfg_wdata    = '0;
		in_valid     = 1'b0;
		op           = acmm_pkg::OP_SAMPLE;
		in_channel   = '0;
		out_channel  = '0;
		sample       = '0;
		gain_value   = '0;
		offset_value = '0;
		out_ready    = 1'b0;
		idle_pct     = 0;
		stall_pct    = 0;
		fail_count   = 0;
		for (int k = 0; k < N_OUT_MAX; k++) begin
			dc_offset[k] = '0;
			for (int m = 0; m < N_IN_MAX; m++)
				gain_coef[k][m] = '0;
		end
		for (int m = 0; m < N_IN_MAX; m++)
			held_sample[m] = '0;
		in_count_reg  = 4'd1;
		out_count_reg = 4'd1;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_saturation_and_floor();
		test_count_limits();
		test_random_traffic(0, 0, 4'd8, 4'd8, 32);
		test_random_traffic(62, 0, NW'($urandom_range(1, 8)), NW'($urandom_range(1, 8)), 32);
		test_random_traffic(0, 62, 4'd1, 4'd1, 32);
		test_random_traffic(20, 20, NW'($urandom), NW'($urandom), 32);

		wait_idle();
		repeat (TRAILER_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("audio_channel_mix_matrix test passed");
		else
			$display("audio_channel_mix_matrix test failed");
		$finish;
	end

	// A correct run takes well under a tenth of this.
	initial begin : watchdog
		#5ms;
		$display("audio_channel_mix_matrix test failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/acmm_pkg.sv
rtl/acmm_fifo.sv
rtl/acmm_front.sv
rtl/acmm_back.sv
rtl/audio_channel_mix_matrix.sv
tb/sv/audio_channel_mix_matrix_test.sv
